// ----- rtl/core/spas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spas_pkg
// Shared types and constants for the sparse polynomial add/sub block.
// ----------------------------------------------------------------------------
package spas_pkg;

   localparam int COEFF_W = 16;
   localparam int EXP_W   = 8;
   localparam int OUT_W   = 17;
   localparam int OP_W    = 3;

   localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SECOND = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD         = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB         = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN1 = 4'b0010,
      ST_SCAN2 = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic ld_first;
      logic ld_second;
      logic rot_first;
      logic rot_second;
      logic clear_match;
      logic mark;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/spas_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spas_cell
// One ring position: a first-store term, a second-store term and its match
// flag. Compares its exponents against a shared key, accumulates loads with
// saturation and shifts toward its neighbor while a scan runs.
// ----------------------------------------------------------------------------
module spas_cell
   import spas_pkg::*;
(
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic                      f_occ,
   input  logic                      s_occ,
   input  logic                      f_new,
   input  logic                      s_new,
   input  logic        [EXP_W-1:0]   key,
   input  logic signed [COEFF_W-1:0] ld_coeff,
   input  logic signed [COEFF_W-1:0] nxt_f_coeff,
   input  logic        [EXP_W-1:0]   nxt_f_exp,
   input  logic signed [COEFF_W-1:0] nxt_s_coeff,
   input  logic        [EXP_W-1:0]   nxt_s_exp,
   input  logic                      nxt_matched,
   output logic signed [COEFF_W-1:0] f_coeff,
   output logic        [EXP_W-1:0]   f_exp,
   output logic signed [COEFF_W-1:0] s_coeff,
   output logic        [EXP_W-1:0]   s_exp,
   output logic                      matched,
   output logic                      f_hit,
   output logic                      s_hit,
   output logic signed [COEFF_W-1:0] s_cmask
);

   logic signed [COEFF_W-1:0] f_coeff_ff, f_coeff_in;
   logic        [EXP_W-1:0]   f_exp_ff, f_exp_in;
   logic signed [COEFF_W-1:0] s_coeff_ff, s_coeff_in;
   logic        [EXP_W-1:0]   s_exp_ff, s_exp_in;
   logic                      matched_ff, matched_in;
   logic signed [COEFF_W:0]   f_sum, s_sum;
   logic signed [COEFF_W-1:0] f_sat, s_sat;

   assign f_hit   = f_occ && (f_exp_ff == key);
   assign s_hit   = s_occ && (s_exp_ff == key);
   assign s_cmask = s_hit ? s_coeff_ff : '0;

   assign f_sum = {f_coeff_ff[COEFF_W-1], f_coeff_ff} + {ld_coeff[COEFF_W-1], ld_coeff};
   assign s_sum = {s_coeff_ff[COEFF_W-1], s_coeff_ff} + {ld_coeff[COEFF_W-1], ld_coeff};

   always_comb begin
      if (f_sum[COEFF_W] != f_sum[COEFF_W-1]) begin
         f_sat = f_sum[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
      end else begin
         f_sat = f_sum[COEFF_W-1:0];
      end
      if (s_sum[COEFF_W] != s_sum[COEFF_W-1]) begin
         s_sat = s_sum[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
      end else begin
         s_sat = s_sum[COEFF_W-1:0];
      end
   end

   always_comb begin
      f_coeff_in = f_coeff_ff;
      f_exp_in   = f_exp_ff;
      s_coeff_in = s_coeff_ff;
      s_exp_in   = s_exp_ff;
      matched_in = matched_ff;
      if (ctrl.rot_first) begin
         f_coeff_in = nxt_f_coeff;
         f_exp_in   = nxt_f_exp;
      end else if (f_new) begin
         f_coeff_in = ld_coeff;
         f_exp_in   = key;
      end else if (ctrl.ld_first && f_hit) begin
         f_coeff_in = f_sat;
      end
      if (ctrl.rot_second) begin
         s_coeff_in = nxt_s_coeff;
         s_exp_in   = nxt_s_exp;
         matched_in = nxt_matched;
      end else begin
         if (s_new) begin
            s_coeff_in = ld_coeff;
            s_exp_in   = key;
         end else if (ctrl.ld_second && s_hit) begin
            s_coeff_in = s_sat;
         end
         if (ctrl.clear_match) begin
            matched_in = 1'b0;
         end else if (ctrl.mark && s_hit) begin
            matched_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      f_coeff_ff <= f_coeff_in;
      f_exp_ff   <= f_exp_in;
      s_coeff_ff <= s_coeff_in;
      s_exp_ff   <= s_exp_in;
      matched_ff <= matched_in;
   end

   assign f_coeff = f_coeff_ff;
   assign f_exp   = f_exp_ff;
   assign s_coeff = s_coeff_ff;
   assign s_exp   = s_exp_ff;
   assign matched = matched_ff;

endmodule

// ----- rtl/core/sparse_polynomial_add_sub.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_sub
// Two sparse polynomial term stores with add, subtract and clear.
// ----------------------------------------------------------------------------
// Load and clear transactions leave the block idle, so they are accepted back
// to back. An add or subtract transaction holds the input off through both
// scans and the flush, plus any output stall (only the flush when both
// stores are empty): the terms sit in a ring of MAX_TERMS cells that rotates
// one position per cycle while the output is not stalled, first the first
// store, then the second, and the head cell feeds the output. Results are
// emitted through a one-item hold stage so the final item carries last_term.
// The rings end each scan in their original order.
module sparse_polynomial_add_sub
   import spas_pkg::*;
#(
   parameter int MAX_TERMS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic        [OP_W-1:0]    req_opcode,
   input  logic signed [COEFF_W-1:0] req_term_coeff,
   input  logic        [EXP_W-1:0]   req_term_exponent,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_W-1:0]   rsp_out_coeff,
   output logic        [EXP_W-1:0]   rsp_out_exponent,
   output logic                      rsp_last_term,
   output logic                      rsp_empty_result,
   output logic                      rsp_load_dropped
);

   localparam int CNT_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT1_W = $clog2(MAX_TERMS + 1);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT1_W-1:0]         fcount_ff, fcount_in;
   logic [CNT1_W-1:0]         scount_ff, scount_in;
   logic                      ovf_ff, ovf_in;
   logic                      sub_ff, sub_in;

   logic                      hold_valid_ff, hold_valid_in;
   logic signed [OUT_W-1:0]   hold_coeff_ff, hold_coeff_in;
   logic [EXP_W-1:0]          hold_exp_ff, hold_exp_in;
   logic                      hold_empty_ff, hold_empty_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   rsp_coeff_ff, rsp_coeff_in;
   logic [EXP_W-1:0]          rsp_exp_ff, rsp_exp_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_drop_ff, rsp_drop_in;

   cell_ctrl_type             ctrl;
   logic                      req_acc, rsp_free, step, any_f_hit, any_s_hit;
   logic                      gen_valid;
   logic signed [OUT_W-1:0]   gen_coeff;
   logic [EXP_W-1:0]          gen_exp;
   logic [EXP_W-1:0]          key;
   logic signed [COEFF_W-1:0] hit_coeff;
   logic [CNT1_W-1:0]         cnt_ext;

   logic signed [COEFF_W-1:0] f_coeff [MAX_TERMS];
   logic        [EXP_W-1:0]   f_exp   [MAX_TERMS];
   logic signed [COEFF_W-1:0] s_coeff [MAX_TERMS];
   logic        [EXP_W-1:0]   s_exp   [MAX_TERMS];
   logic signed [COEFF_W-1:0] s_cmask [MAX_TERMS];
   logic [MAX_TERMS-1:0]      matched, f_hit, s_hit, f_occ, s_occ, f_new, s_new;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = rsp_free;
   assign cnt_ext   = CNT1_W'(cnt_ff);
   assign key       = (state_ff == ST_SCAN1) ? f_exp[0] : req_term_exponent;
   assign any_f_hit = |f_hit;
   assign any_s_hit = |s_hit;

   always_comb begin
      hit_coeff = '0;
      for (int k = 0; k < MAX_TERMS; k++) begin
         hit_coeff = hit_coeff | s_cmask[k];
      end
   end

   always_comb begin
      ctrl             = '0;
      ctrl.ld_first    = req_acc && (req_opcode == OP_LOAD_FIRST);
      ctrl.ld_second   = req_acc && (req_opcode == OP_LOAD_SECOND);
      ctrl.rot_first   = (state_ff == ST_SCAN1) && step;
      ctrl.rot_second  = (state_ff == ST_SCAN2) && step;
      ctrl.clear_match = req_acc && ((req_opcode == OP_ADD) || (req_opcode == OP_SUB));
      ctrl.mark        = (state_ff == ST_SCAN1) && step && (cnt_ext < fcount_ff);
   end

   genvar g;
   generate
      for (g = 0; g < MAX_TERMS; g++) begin : g_cell
         localparam int NXT = (g + 1) % MAX_TERMS;
         assign f_occ[g] = (CNT1_W'(g) < fcount_ff);
         assign s_occ[g] = (CNT1_W'(g) < scount_ff);
         assign f_new[g] = ctrl.ld_first && !any_f_hit && (fcount_ff == CNT1_W'(g));
         assign s_new[g] = ctrl.ld_second && !any_s_hit && (scount_ff == CNT1_W'(g));
         spas_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .f_occ       (f_occ[g]),
            .s_occ       (s_occ[g]),
            .f_new       (f_new[g]),
            .s_new       (s_new[g]),
            .key         (key),
            .ld_coeff    (req_term_coeff),
            .nxt_f_coeff (f_coeff[NXT]),
            .nxt_f_exp   (f_exp[NXT]),
            .nxt_s_coeff (s_coeff[NXT]),
            .nxt_s_exp   (s_exp[NXT]),
            .nxt_matched (matched[NXT]),
            .f_coeff     (f_coeff[g]),
            .f_exp       (f_exp[g]),
            .s_coeff     (s_coeff[g]),
            .s_exp       (s_exp[g]),
            .matched     (matched[g]),
            .f_hit       (f_hit[g]),
            .s_hit       (s_hit[g]),
            .s_cmask     (s_cmask[g])
         );
      end
   endgenerate

   // term generator, head of the ring
   always_comb begin
      gen_valid = 1'b0;
      gen_coeff = '0;
      gen_exp   = '0;
      case (state_ff)
         ST_SCAN1: begin
            gen_valid = step && (cnt_ext < fcount_ff);
            gen_exp   = f_exp[0];
            gen_coeff = sub_ff
               ? OUT_W'(f_coeff[0]) - OUT_W'(hit_coeff)
               : OUT_W'(f_coeff[0]) + OUT_W'(hit_coeff);
         end
         ST_SCAN2: begin
            gen_valid = step && (cnt_ext < scount_ff) && !matched[0];
            gen_exp   = s_exp[0];
            gen_coeff = sub_ff ? -OUT_W'(s_coeff[0]) : OUT_W'(s_coeff[0]);
         end
         default: begin
            gen_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      fcount_in     = fcount_ff;
      scount_in     = scount_ff;
      ovf_in        = ovf_ff;
      sub_in        = sub_ff;
      hold_valid_in = hold_valid_ff;
      hold_coeff_in = hold_coeff_ff;
      hold_exp_in   = hold_exp_ff;
      hold_empty_in = hold_empty_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_coeff_in  = rsp_coeff_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_drop_in   = rsp_drop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (ctrl.ld_first && !any_f_hit) begin
               if (fcount_ff == CNT1_W'(MAX_TERMS)) begin
                  ovf_in = 1'b1;
               end else begin
                  fcount_in = fcount_ff + 1'b1;
               end
            end
            if (ctrl.ld_second && !any_s_hit) begin
               if (scount_ff == CNT1_W'(MAX_TERMS)) begin
                  ovf_in = 1'b1;
               end else begin
                  scount_in = scount_ff + 1'b1;
               end
            end
            if (req_acc && (req_opcode == OP_CLEAR)) begin
               fcount_in = '0;
               scount_in = '0;
               ovf_in    = 1'b0;
            end
            if (ctrl.clear_match) begin
               sub_in = (req_opcode == OP_SUB);
               cnt_in = '0;
               if ((fcount_ff == '0) && (scount_ff == '0)) begin
                  hold_valid_in = 1'b1;
                  hold_coeff_in = '0;
                  hold_exp_in   = '0;
                  hold_empty_in = 1'b1;
                  state_in      = ST_FLUSH;
               end else begin
                  state_in = ST_SCAN1;
               end
            end
         end
         ST_SCAN1, ST_SCAN2: begin
            if (step) begin
               if (cnt_ff == CNT_W'(MAX_TERMS - 1)) begin
                  cnt_in   = '0;
                  state_in = (state_ff == ST_SCAN1) ? ST_SCAN2 : ST_FLUSH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if (gen_valid) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_coeff_in = hold_coeff_ff;
                  rsp_exp_in   = hold_exp_ff;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = hold_empty_ff;
                  rsp_drop_in  = ovf_ff;
               end
               hold_valid_in = 1'b1;
               hold_coeff_in = gen_coeff;
               hold_exp_in   = gen_exp;
               hold_empty_in = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_coeff_in  = hold_coeff_ff;
               rsp_exp_in    = hold_exp_ff;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = hold_empty_ff;
               rsp_drop_in   = ovf_ff;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         fcount_ff     <= '0;
         scount_ff     <= '0;
         ovf_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         fcount_ff     <= fcount_in;
         scount_ff     <= scount_in;
         ovf_ff        <= ovf_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sub_ff        <= sub_in;
      hold_coeff_ff <= hold_coeff_in;
      hold_exp_ff   <= hold_exp_in;
      hold_empty_ff <= hold_empty_in;
      rsp_coeff_ff  <= rsp_coeff_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_coeff    = rsp_coeff_ff;
   assign rsp_out_exponent = rsp_exp_ff;
   assign rsp_last_term    = rsp_last_ff;
   assign rsp_empty_result = rsp_empty_ff;
   assign rsp_load_dropped = rsp_drop_ff;

`ifndef ASSERT_OFF
   a_f_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> $onehot0(f_hit))
      else $error("first store holds a repeated exponent");

   a_s_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> $onehot0(s_hit))
      else $error("second store holds a repeated exponent");

   a_flush_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> hold_valid_ff)
      else $error("flush with no pending result term");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("pending result term left behind in idle");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_result) |-> rsp_last_term)
      else $error("empty result not marked as final transaction");
`endif

endmodule

// ----- bench/sparse_polynomial_add_sub_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_sub_test
// Self-checking bench for the sparse polynomial add/sub block.
// ----------------------------------------------------------------------------
// A driver pulls requests from a pending queue (directed cases, then random
// load/combine sequences with noise) and presents them with random gaps. A
// monitor checks each result term against a queue filled by a local
// predictor of both term stores, and feeds every accepted request to it. The
// receiver stalls at random, once for a long stretch so that the block backs
// up, and the sender drains the block completely now and then.
module sparse_polynomial_add_sub_test;
   import spas_pkg::*;

   localparam int TERM_SLOTS = 16;
   localparam int LONG_HOLD  = 300;
   localparam int STIM_ITEMS = 350;
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [COEFF_W-1:0] coeff;
      logic [EXP_W-1:0]         exponent;
      bit                       drain;
      bit                       hold;
   } poly_req_type;

   typedef struct {
      logic signed [OUT_W-1:0] coeff;
      logic [EXP_W-1:0]        exponent;
      bit                      last;
      bit                      empty;
      bit                      dropped;
   } term_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_opcode = OP_CLEAR;
   logic signed [COEFF_W-1:0] req_term_coeff = '0;
   logic [EXP_W-1:0]          req_term_exponent = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]   rsp_out_coeff;
   logic [EXP_W-1:0]          rsp_out_exponent;
   logic                      rsp_last_term;
   logic                      rsp_empty_result;
   logic                      rsp_load_dropped;

   sparse_polynomial_add_sub #(.MAX_TERMS(TERM_SLOTS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_term_coeff    (req_term_coeff),
      .req_term_exponent (req_term_exponent),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_coeff     (rsp_out_coeff),
      .rsp_out_exponent  (rsp_out_exponent),
      .rsp_last_term     (rsp_last_term),
      .rsp_empty_result  (rsp_empty_result),
      .rsp_load_dropped  (rsp_load_dropped)
   );

   // predictor state: polynomial P (first store) and Q (second store)
   logic signed [COEFF_W-1:0] p_coeff [TERM_SLOTS];
   logic [EXP_W-1:0]          p_exp   [TERM_SLOTS];
   int                        p_count = 0;
   logic signed [COEFF_W-1:0] q_coeff [TERM_SLOTS];
   logic [EXP_W-1:0]          q_exp   [TERM_SLOTS];
   int                        q_count = 0;
   bit                        drop_flag = 1'b0;

   poly_req_type    pending_reqs [$];
   term_result_type expected_terms [$];
   poly_req_type    next_req;
   term_result_type want;
   int           items_built = 0;
   bit           drain_next = 1'b0;
   bit           hold_next = 1'b0;
   int           sent_count = 0;
   int           taken_count = 0;
   int           hold_asked = 0;
   int           hold_taken = 0;
   int           hold_left = 0;
   int           tx_gap = 0;
   int           tx_burst = 0;
   int           rx_gap = 0;
   int           rx_burst = 0;
   int           errors = 0;

   function automatic void merge_term(bit into_q, logic signed [COEFF_W-1:0] c,
                                      logic [EXP_W-1:0] e);
      int n;
      int hit;
      int s;
      n = into_q ? q_count : p_count;
      hit = -1;
      for (int k = 0; k < n; k++) begin
         if ((into_q ? q_exp[k] : p_exp[k]) == e) hit = k;
      end
      if (hit >= 0) begin
         s = (into_q ? q_coeff[hit] : p_coeff[hit]) + c;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         if (into_q) q_coeff[hit] = s[COEFF_W-1:0];
         else p_coeff[hit] = s[COEFF_W-1:0];
      end else if (n < TERM_SLOTS) begin
         if (into_q) begin
            q_coeff[n] = c;
            q_exp[n] = e;
            q_count++;
         end else begin
            p_coeff[n] = c;
            p_exp[n] = e;
            p_count++;
         end
      end else begin
         drop_flag = 1'b1;
      end
   endfunction

   function automatic term_result_type make_term(int v, logic [EXP_W-1:0] e, bit empty);
      term_result_type r;
      r.coeff = v[OUT_W-1:0];
      r.exponent = e;
      r.last = 1'b0;
      r.empty = empty;
      r.dropped = drop_flag;
      return r;
   endfunction

   function automatic void combine_terms(bit subtract);
      term_result_type batch [$];
      bit used [TERM_SLOTS];
      int v;
      foreach (used[k]) used[k] = 1'b0;
      if (p_count == 0 && q_count == 0) begin
         batch.push_back(make_term(0, '0, 1'b1));
      end else begin
         for (int i = 0; i < p_count; i++) begin
            v = p_coeff[i];
            for (int j = 0; j < q_count; j++) begin
               if (!used[j] && q_exp[j] == p_exp[i]) begin
                  used[j] = 1'b1;
                  v = subtract ? v - q_coeff[j] : v + q_coeff[j];
                  break;
               end
            end
            batch.push_back(make_term(v, p_exp[i], 1'b0));
         end
         for (int j = 0; j < q_count; j++) begin
            if (!used[j]) begin
               v = q_coeff[j];
               batch.push_back(make_term(subtract ? -v : v, q_exp[j], 1'b0));
            end
         end
      end
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) expected_terms.push_back(batch[k]);
   endfunction

   function automatic void apply_request(logic [OP_W-1:0] op, logic signed [COEFF_W-1:0] c,
                                         logic [EXP_W-1:0] e);
      case (op)
         OP_LOAD_FIRST: merge_term(1'b0, c, e);
         OP_LOAD_SECOND: merge_term(1'b1, c, e);
         OP_ADD: combine_terms(1'b0);
         OP_SUB: combine_terms(1'b1);
         OP_CLEAR: begin
            p_count = 0;
            q_count = 0;
            drop_flag = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap(int calm_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < calm_pct) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic signed [COEFF_W-1:0] rand_coeff();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sh7FFF;
      if (r == 1) return 16'sh8000;
      if (r < 4) begin
         v = $urandom_range(0, 200);
         v = v - 100;
         return v[COEFF_W-1:0];
      end
      v = $urandom;
      return v[COEFF_W-1:0];
   endfunction

   function automatic logic [EXP_W-1:0] rand_exp(int base, int span);
      int v;
      v = base + $urandom_range(0, span);
      return v[EXP_W-1:0];
   endfunction

   function automatic int pick_count();
      if ($urandom_range(0, 5) == 0) return $urandom_range(12, 18);
      return $urandom_range(0, 6);
   endfunction

   task automatic queue_item(logic [OP_W-1:0] op, logic signed [COEFF_W-1:0] c,
                             logic [EXP_W-1:0] e);
      poly_req_type it;
      it.op = op;
      it.coeff = c;
      it.exponent = e;
      it.drain = drain_next;
      it.hold = hold_next;
      drain_next = 1'b0;
      hold_next = 1'b0;
      pending_reqs.push_back(it);
      if (op <= OP_CLEAR) items_built++;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && sent_count != taken_count) begin
         // transaction still waiting, payload holds
      end else if (tx_gap > 0) begin
         req_valid <= 1'b0;
         tx_gap <= tx_gap - 1;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && expected_terms.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         next_req = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_opcode <= next_req.op;
         req_term_coeff <= next_req.coeff;
         req_term_exponent <= next_req.exponent;
         sent_count <= sent_count + 1;
         if (next_req.hold) hold_asked <= hold_asked + 1;
         if (tx_burst > 0) begin
            tx_burst <= tx_burst - 1;
            tx_gap <= 0;
         end else begin
            if ($urandom_range(0, 49) == 0) tx_burst <= $urandom_range(20, 60);
            tx_gap <= pick_gap(55);
         end
      end
   end

   // result stall generator
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rx_burst > 0) begin
            rx_burst <= rx_burst - 1;
         end else begin
            if ($urandom_range(0, 99) == 0) rx_burst <= $urandom_range(30, 80);
            rx_gap <= pick_gap(70);
         end
      end
   end

   // monitor: check results, then predict from the accepted request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_terms.size() == 0) begin
               $error("unexpected result term: coeff %0d exponent %0d",
                      rsp_out_coeff, rsp_out_exponent);
               errors++;
            end else begin
               want = expected_terms.pop_front();
               if (rsp_out_coeff !== want.coeff) begin
                  $error("out_coeff: expected %0d, got %0d", want.coeff, rsp_out_coeff);
                  errors++;
               end
               if (rsp_out_exponent !== want.exponent) begin
                  $error("out_exponent: expected %0d, got %0d", want.exponent,
                         rsp_out_exponent);
                  errors++;
               end
               if (rsp_last_term !== want.last) begin
                  $error("last_term: expected %0d, got %0d", want.last, rsp_last_term);
                  errors++;
               end
               if (rsp_empty_result !== want.empty) begin
                  $error("empty_result: expected %0d, got %0d", want.empty,
                         rsp_empty_result);
                  errors++;
               end
               if (rsp_load_dropped !== want.dropped) begin
                  $error("load_dropped: expected %0d, got %0d", want.dropped,
                         rsp_load_dropped);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_opcode, req_term_coeff, req_term_exponent);
            taken_count++;
         end
      end
   end

   initial begin : stimulus
      int seq;
      int np;
      int nq;
      int n_ops;
      int base;
      int span;
      int r;
      int noise;

      // directed: empty stores, unused opcodes, saturation, extremes
      queue_item(OP_ADD, '0, '0);
      queue_item(OP_SUB, '0, '0);
      for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
         queue_item(k[OP_W-1:0], rand_coeff(), rand_exp(0, 255));
      queue_item(OP_LOAD_FIRST, 16'sh7FFF, 8'd255);
      queue_item(OP_LOAD_FIRST, 16'sh7FFF, 8'd255);
      queue_item(OP_LOAD_FIRST, 16'sh8000, 8'd0);
      queue_item(OP_LOAD_FIRST, -16'sd1, 8'd0);
      queue_item(OP_LOAD_SECOND, 16'sh8000, 8'd255);
      queue_item(OP_LOAD_SECOND, 16'sh8000, 8'd0);
      queue_item(OP_LOAD_SECOND, 16'sd5, 8'd17);
      queue_item(OP_LOAD_SECOND, 16'sd0, 8'd128);
      queue_item(OP_ADD, '0, '0);
      queue_item(OP_SUB, '0, '0);
      queue_item(OP_LOAD_FIRST, 16'sd100, 8'd9);
      queue_item(OP_LOAD_SECOND, -16'sd100, 8'd9);
      queue_item(OP_ADD, '0, '0);
      queue_item(OP_LOAD_FIRST, 16'sh5555, 8'hAA);
      queue_item(OP_LOAD_SECOND, 16'shAAAA, 8'h55);
      queue_item(OP_SUB, 16'shFFFF, 8'hFF);
      queue_item(OP_CLEAR, '0, '0);
      queue_item(OP_LOAD_SECOND, 16'sh8000, 8'd3);
      queue_item(OP_SUB, '0, '0);
      queue_item(OP_CLEAR, '0, '0);
      queue_item(OP_LOAD_FIRST, 16'sd7, 8'd1);
      queue_item(OP_ADD, '0, '0);

      // random: mostly clear/load/combine sequences, some noise
      seq = 0;
      while (items_built < STIM_ITEMS) begin
         if (seq % 12 == 5) drain_next = 1'b1;
         if (seq != 3 && $urandom_range(0, 9) == 0) begin
            noise = $urandom_range(1, 4);
            for (int k = 0; k < noise; k++) begin
               r = $urandom_range(0, OP_UNUSED_LAST);
               queue_item(r[OP_W-1:0], rand_coeff(), rand_exp(0, 255));
            end
         end else begin
            if ($urandom_range(0, 3) != 0) queue_item(OP_CLEAR, rand_coeff(), rand_exp(0, 255));
            r = $urandom_range(0, 2);
            span = (r == 0) ? 7 : (r == 1) ? 31 : 255;
            base = $urandom_range(0, 255);
            np = pick_count();
            nq = pick_count();
            if (seq == 3) begin
               np = TERM_SLOTS;
               nq = TERM_SLOTS;
               span = 255;
            end
            while (np > 0 || nq > 0) begin
               if (nq == 0 || (np > 0 && $urandom_range(0, 1) == 1)) begin
                  queue_item(OP_LOAD_FIRST, rand_coeff(), rand_exp(base, span));
                  np--;
               end else begin
                  queue_item(OP_LOAD_SECOND, rand_coeff(), rand_exp(base, span));
                  nq--;
               end
            end
            n_ops = $urandom_range(1, 2);
            for (int k = 0; k < n_ops; k++) begin
               if (seq == 3 && k == 0) hold_next = 1'b1;
               queue_item($urandom_range(0, 1) ? OP_SUB : OP_ADD, rand_coeff(),
                          rand_exp(0, 255));
            end
         end
         seq++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_reqs.size() != 0 || sent_count != taken_count) @(posedge clock);
      while (expected_terms.size() != 0) @(posedge clock);
      repeat (2 * TERM_SLOTS + 40) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
